### hw/rtl/prat_pkg.sv
// Shared types and constants of the page run allocation table.
package prat_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int PAGE_SHIFT    = 12;

    localparam int ADDR_W  = 32;
    localparam int PAGES_W = 10;
    localparam int OWNER_W = 16;
    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
    // running page index: up to TABLE_ENTRIES counts plus the request itself
    localparam int SUM_W   = PAGES_W + CNT_W;

    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAP_START = 1'b0,
        CFG_STACK_TOP  = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        KIND_FREE  = 2'd0,
        KIND_HEAP  = 2'd1,
        KIND_STACK = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO     = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef struct packed {
        kind_t               kind;
        logic [ADDR_W-1:0]   base;
        logic [PAGES_W-1:0]  pages;
        logic [OWNER_W-1:0]  owner;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } mem_wr_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        status_t           status;
        logic              reused;
    } result_t;

endpackage

### hw/rtl/prat_table_ram.sv
// Entry memory of the run table: one write port, one registered read port.
module prat_table_ram (
    input  logic                         aclk,
    input  prat_pkg::mem_wr_t            wr,
    input  logic [prat_pkg::IDX_W-1:0]   rd_addr,
    output prat_pkg::entry_t             rd_data
);

    prat_pkg::entry_t mem [prat_pkg::TABLE_ENTRIES];
    prat_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/prat_scan.sv
// Request sequencer: scans the run table, reuses, frees or appends entries.
module prat_scan (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [prat_pkg::ADDR_W-1:0]     heap_start,
    input  logic [prat_pkg::ADDR_W-1:0]     stack_top,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  logic                            req_func,
    input  logic                            req_run_kind,
    input  logic [prat_pkg::PAGES_W-1:0]    req_page_count,
    input  logic [prat_pkg::OWNER_W-1:0]    req_owner_pid,
    input  logic [prat_pkg::ADDR_W-1:0]     req_run_address,
    output logic [prat_pkg::IDX_W-1:0]      rd_addr,
    input  prat_pkg::entry_t                rd_data,
    output prat_pkg::mem_wr_t               wr,
    output logic                            res_valid,
    input  logic                            res_ready,
    output prat_pkg::result_t               res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPEND,
        S_DONE
    } state_t;

    state_t                          state_reg, state_next;
    prat_pkg::func_t                 func_reg, func_next;
    prat_pkg::kind_t                 kind_reg, kind_next;
    logic [prat_pkg::PAGES_W-1:0]    cnt_reg, cnt_next;
    logic [prat_pkg::OWNER_W-1:0]    pid_reg, pid_next;
    logic [prat_pkg::ADDR_W-1:0]     base_reg, base_next;
    logic [prat_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic [prat_pkg::SUM_W-1:0]      sum_reg, sum_next;
    logic [prat_pkg::CNT_W-1:0]      used_reg, used_next;
    prat_pkg::result_t               res_reg, res_next;

    prat_pkg::entry_t                upd_entry;
    logic                            last_entry;
    logic [prat_pkg::SUM_W-1:0]      span;
    logic [prat_pkg::ADDR_W-1:0]     heap_addr;

    assign last_entry = (prat_pkg::CNT_W'(idx_reg) + prat_pkg::CNT_W'(1)) == used_reg;
    assign span       = sum_reg + prat_pkg::SUM_W'(cnt_reg);
    assign heap_addr  = heap_start - (prat_pkg::ADDR_W'(span) << prat_pkg::PAGE_SHIFT);

    // entry 0 is fetched while idle so its data is ready on the first scan cycle
    assign rd_addr   = (state_reg == S_IDLE) ? '0 : idx_reg + prat_pkg::IDX_W'(1);
    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_comb begin
        state_next = state_reg;
        func_next  = func_reg;
        kind_next  = kind_reg;
        cnt_next   = cnt_reg;
        pid_next   = pid_reg;
        base_next  = base_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        used_next  = used_reg;
        res_next   = res_reg;
        wr         = '0;
        upd_entry  = rd_data;

        unique case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    func_next = prat_pkg::func_t'(req_func);
                    kind_next = req_run_kind ? prat_pkg::KIND_STACK : prat_pkg::KIND_HEAP;
                    cnt_next  = req_page_count;
                    pid_next  = req_owner_pid;
                    base_next = req_run_address;
                    idx_next  = '0;
                    sum_next  = '0;
                    if (req_func == prat_pkg::FUNC_ALLOC && req_page_count == '0) begin
                        res_next   = '{'0, prat_pkg::ST_ZERO, 1'b0};
                        state_next = S_DONE;
                    end else if (used_reg == '0) begin
                        if (req_func == prat_pkg::FUNC_FREE) begin
                            res_next   = '{'0, prat_pkg::ST_NOTFOUND, 1'b0};
                            state_next = S_DONE;
                        end else begin
                            state_next = S_APPEND;
                        end
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                if (func_reg == prat_pkg::FUNC_ALLOC) begin
                    if (rd_data.kind == kind_reg || rd_data.kind == prat_pkg::KIND_FREE) begin
                        sum_next = sum_reg + prat_pkg::SUM_W'(rd_data.pages);
                    end
                    if (rd_data.kind == prat_pkg::KIND_FREE && rd_data.pages == cnt_reg &&
                        rd_data.owner == pid_reg) begin
                        upd_entry.kind = kind_reg;
                        wr = '{1'b1, idx_reg, upd_entry};
                        res_next = '{(kind_reg == prat_pkg::KIND_STACK) ? stack_top
                                                                        : rd_data.base,
                                     prat_pkg::ST_OK, 1'b1};
                        state_next = S_DONE;
                    end else if (last_entry) begin
                        state_next = S_APPEND;
                    end else begin
                        idx_next = idx_reg + prat_pkg::IDX_W'(1);
                    end
                end else begin
                    if (rd_data.base == base_reg) begin
                        upd_entry.kind  = prat_pkg::KIND_FREE;
                        upd_entry.pages = cnt_reg;
                        wr = '{1'b1, idx_reg, upd_entry};
                        res_next   = '{'0, prat_pkg::ST_OK, 1'b0};
                        state_next = S_DONE;
                    end else if (last_entry) begin
                        res_next   = '{'0, prat_pkg::ST_NOTFOUND, 1'b0};
                        state_next = S_DONE;
                    end else begin
                        idx_next = idx_reg + prat_pkg::IDX_W'(1);
                    end
                end
            end

            S_APPEND: begin
                if (used_reg >= prat_pkg::CNT_W'(prat_pkg::TABLE_ENTRIES)) begin
                    res_next = '{'0, prat_pkg::ST_FULL, 1'b0};
                end else begin
                    upd_entry.kind  = kind_reg;
                    upd_entry.base  = (kind_reg == prat_pkg::KIND_HEAP) ? heap_addr : heap_start;
                    upd_entry.pages = cnt_reg;
                    upd_entry.owner = pid_reg;
                    wr = '{1'b1, used_reg[prat_pkg::IDX_W-1:0], upd_entry};
                    used_next = used_reg + prat_pkg::CNT_W'(1);
                    res_next  = '{(kind_reg == prat_pkg::KIND_STACK) ? stack_top : heap_addr,
                                  prat_pkg::ST_OK, 1'b0};
                end
                state_next = S_DONE;
            end

            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
        end
        func_reg <= func_next;
        kind_reg <= kind_next;
        cnt_reg  <= cnt_next;
        pid_reg  <= pid_next;
        base_reg <= base_next;
        idx_reg  <= idx_next;
        sum_reg  <= sum_next;
        res_reg  <= res_next;
    end

endmodule

### hw/rtl/page_run_allocation_table.sv
// Top level of the page run allocation table: registers, sequencer, memory, output stage.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------------
//  request  | s_valid / s_ready  | s_func s_run_kind s_page_count s_owner_pid s_run_address
//  result   | m_valid / m_ready  | m_address m_status m_reused
//  config   | cfg_wr_en          | cfg_index cfg_wr_data
//
// A request scans the entries below the fill count in order and stops at a match; an
// allocation that reuses no free run appends an entry, or reports a full table.
// The single memory read port gives one entry per cycle to the scan; zero counts skip it.
// Reset clears the configuration registers, the sequencer state, the fill count and the
// output valid flag; entries are never cleared, only those below the fill count are used.
// A result waits in the output register, so the next request is taken while m_ready is low.
module page_run_allocation_table (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [prat_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [prat_pkg::ADDR_W-1:0]         cfg_wr_data,
    // request channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_func,
    input  logic                                s_run_kind,
    input  logic [prat_pkg::PAGES_W-1:0]        s_page_count,
    input  logic [prat_pkg::OWNER_W-1:0]        s_owner_pid,
    input  logic [prat_pkg::ADDR_W-1:0]         s_run_address,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [prat_pkg::ADDR_W-1:0]         m_address,
    output logic [1:0]                          m_status,
    output logic                                m_reused
);

    logic [prat_pkg::ADDR_W-1:0]  heap_start_reg;
    logic [prat_pkg::ADDR_W-1:0]  stack_top_reg;

    logic                         m_valid_reg;
    prat_pkg::result_t            m_res_reg;

    logic [prat_pkg::IDX_W-1:0]   rd_addr;
    prat_pkg::entry_t             rd_data;
    prat_pkg::mem_wr_t            wr;
    logic                         res_valid;
    logic                         res_ready;
    prat_pkg::result_t            res;

    // configuration writes land directly, unchecked; the user keeps them to idle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_start_reg <= '0;
            stack_top_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (prat_pkg::cfg_reg_t'(cfg_index))
                prat_pkg::CFG_HEAP_START: heap_start_reg <= cfg_wr_data;
                prat_pkg::CFG_STACK_TOP:  stack_top_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    prat_scan u_scan (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .heap_start      (heap_start_reg),
        .stack_top       (stack_top_reg),
        .req_valid       (s_valid),
        .req_ready       (s_ready),
        .req_func        (s_func),
        .req_run_kind    (s_run_kind),
        .req_page_count  (s_page_count),
        .req_owner_pid   (s_owner_pid),
        .req_run_address (s_run_address),
        .rd_addr         (rd_addr),
        .rd_data         (rd_data),
        .wr              (wr),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res             (res)
    );

    prat_table_ram u_ram (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // output stage: advance a finished result whenever the register is empty or draining
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_address = m_res_reg.address;
    assign m_status  = m_res_reg.status;
    assign m_reused  = m_res_reg.reused;

endmodule

### hw/rtl/prat_checker.sv
// Port-level checks of the page run allocation table, bound to the top level.
module prat_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [prat_pkg::ADDR_W-1:0]         m_address,
    input  logic [1:0]                          m_status,
    input  logic                                m_reused
);

    // no result survives a reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a failed request carries neither an address nor a reuse flag
    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != prat_pkg::ST_OK |-> m_address == '0 && !m_reused)
        else $error("failed result carries address or reuse flag");

    // reuse only comes with success
    a_reuse_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reused |-> m_status == prat_pkg::ST_OK)
        else $error("reuse flagged on a failed result");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_address) && $stable(m_status)
                                && $stable(m_reused))
        else $error("stalled result changed");

endmodule

bind page_run_allocation_table prat_checker u_prat_checker (.*);
